FILE: rtl/psd_pkg.sv
// Shared constants, types and helpers of the point to segment distance block.
`timescale 1ns / 1ps

package psd_pkg;

   // Default coordinate width, signed Q16.16
   localparam int COORD_WIDTH_DEFAULT = 32;

   // Number of configuration registers (start x, y, z then end x, y, z)
   localparam int REG_COUNT = 6;

   // Region codes of a result
   localparam logic [1:0] REGION_START      = 2'd0;
   localparam logic [1:0] REGION_INTERIOR   = 2'd1;
   localparam logic [1:0] REGION_END        = 2'd2;
   localparam logic [1:0] REGION_DEGENERATE = 2'd3;

   // Control that travels with each request down the pipeline
   typedef struct packed {
      logic       valid;
      logic [1:0] region;
   } ctl_type;

   // Register bus data width: 64 bits once a coordinate no longer fits 32
   function automatic int csr_data_width(input int coord_width);
      return (coord_width > 32) ? 64 : 32;
   endfunction

   // Byte address width: three index bits above the register stride
   function automatic int csr_addr_width(input int coord_width);
      return ((coord_width > 32) ? 3 : 2) + 3;
   endfunction

endpackage

FILE: rtl/psd_csr.sv
// Segment end point registers behind the APB-style register port.
`timescale 1ns / 1ps

module psd_csr import psd_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_psel,
   input  logic                                      csr_penable,
   input  logic                                      csr_pwrite,
   input  logic [csr_addr_width(COORD_WIDTH)-1:0]    csr_paddr,
   input  logic [csr_data_width(COORD_WIDTH)-1:0]    csr_pwdata,
   output logic [csr_data_width(COORD_WIDTH)-1:0]    csr_prdata,
   output logic                                      csr_pready,
   output logic [2:0][COORD_WIDTH-1:0]               seg_start,
   output logic [2:0][COORD_WIDTH-1:0]               seg_end
);

   localparam int W      = COORD_WIDTH;
   localparam int DATA_W = csr_data_width(COORD_WIDTH);
   localparam int ADDR_W = csr_addr_width(COORD_WIDTH);
   localparam int LSB    = ADDR_W - 3;

   logic [W-1:0] seg_ff [REG_COUNT];
   logic [2:0]   index;
   logic         index_ok;

   assign index    = csr_paddr[ADDR_W-1:LSB];
   assign index_ok = (index < 3'(REG_COUNT));

   // Take a write in the access phase; drop writes beyond the register list
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            seg_ff[i] <= '0;
         end
      end else if (csr_psel && csr_penable && csr_pwrite && index_ok) begin
         seg_ff[index] <= csr_pwdata[W-1:0];
      end
   end

   // Return the addressed register, zero beyond the list
   always_comb begin
      csr_prdata = '0;
      if (index_ok) begin
         csr_prdata = DATA_W'(seg_ff[index]);
      end
   end

   assign csr_pready = 1'b1;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         seg_start[k] = seg_ff[k];
         seg_end[k]   = seg_ff[3 + k];
      end
   end

endmodule

FILE: rtl/psd_front.sv
// Front pipeline: differences, products and the dot and length sums.
`timescale 1ns / 1ps

module psd_front import psd_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic [2:0][COORD_WIDTH-1:0]        in_q,
   input  logic [2:0][COORD_WIDTH-1:0]        seg_start,
   input  logic [2:0][COORD_WIDTH-1:0]        seg_end,
   output logic                               out_valid,
   output logic [2:0][COORD_WIDTH-1:0]        out_q,
   output logic [2:0][COORD_WIDTH:0]          out_c,
   output logic [2*COORD_WIDTH+3:0]           out_dot,
   output logic [2*COORD_WIDTH+1:0]           out_len
);

   localparam int W  = COORD_WIDTH;
   localparam int AW = W + 1;
   localparam int PW = 2 * AW;
   localparam int DW = 2 * W + 4;
   localparam int LW = 2 * W + 2;

   logic                 v1_ff, v2_ff, v3_ff;
   logic [2:0][W-1:0]    q1_ff, q2_ff, q3_ff;
   logic [2:0][AW-1:0]   a1_ff, c1_ff, c2_ff, c3_ff;
   logic [2:0][PW-1:0]   ac2_ff, cc2_ff;
   logic [DW-1:0]        dot3_ff;
   logic [LW-1:0]        len3_ff;

   logic [2:0][AW-1:0]   a_in, c_in;
   logic [2:0][PW-1:0]   ac_in, cc_in;
   logic [DW-1:0]        dot_in;
   logic [LW-1:0]        len_in;

   // Form query minus start and end minus start
   for (genvar k = 0; k < 3; k++) begin : g_diff
      assign a_in[k] = {in_q[k][W-1], in_q[k]} - {seg_start[k][W-1], seg_start[k]};
      assign c_in[k] = {seg_end[k][W-1], seg_end[k]} - {seg_start[k][W-1], seg_start[k]};
      assign ac_in[k] = $signed(a1_ff[k]) * $signed(c1_ff[k]);
      assign cc_in[k] = $signed(c1_ff[k]) * $signed(c1_ff[k]);
   end

   // Sum the products exactly
   assign dot_in = {{2{ac2_ff[0][PW-1]}}, ac2_ff[0]}
                 + {{2{ac2_ff[1][PW-1]}}, ac2_ff[1]}
                 + {{2{ac2_ff[2][PW-1]}}, ac2_ff[2]};
   assign len_in = {2'b00, cc2_ff[0][2*W-1:0]}
                 + {2'b00, cc2_ff[1][2*W-1:0]}
                 + {2'b00, cc2_ff[2][2*W-1:0]};

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         q1_ff   <= in_q;
         a1_ff   <= a_in;
         c1_ff   <= c_in;
         q2_ff   <= q1_ff;
         c2_ff   <= c1_ff;
         ac2_ff  <= ac_in;
         cc2_ff  <= cc_in;
         q3_ff   <= q2_ff;
         c3_ff   <= c2_ff;
         dot3_ff <= dot_in;
         len3_ff <= len_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_q     = q3_ff;
   assign out_c     = c3_ff;
   assign out_dot   = dot3_ff;
   assign out_len   = len3_ff;

endmodule

FILE: rtl/psd_scale.sv
// Region decision and pipelined multiply-divide that places the nearest point.
`timescale 1ns / 1ps

module psd_scale import psd_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic [2:0][COORD_WIDTH-1:0]        in_q,
   input  logic [2:0][COORD_WIDTH:0]          in_c,
   input  logic [2*COORD_WIDTH+3:0]           in_dot,
   input  logic [2*COORD_WIDTH+1:0]           in_len,
   input  logic [2:0][COORD_WIDTH-1:0]        seg_start,
   input  logic [2:0][COORD_WIDTH-1:0]        seg_end,
   output ctl_type                            out_ctl,
   output logic [2:0][COORD_WIDTH-1:0]        out_q,
   output logic [2:0][COORD_WIDTH-1:0]        out_n
);

   localparam int W  = COORD_WIDTH;
   localparam int AW = W + 1;
   localparam int DW = 2 * W + 4;
   localparam int LW = 2 * W + 2;
   localparam int RW = LW + 1;

   ctl_type               ctl_ff   [W+1];
   ctl_type               ctl_in   [W+1];
   logic [2:0][RW-1:0]    r_ff     [W+1];
   logic [2:0][RW-1:0]    r_in     [W+1];
   logic [2:0][W-1:0]     qq_ff    [W+1];
   logic [2:0][W-1:0]     qq_in    [W+1];
   logic [2:0][W-1:0]     cmag_ff  [W+1];
   logic [2:0][W-1:0]     cmag_in  [W+1];
   logic [2:0]            cneg_ff  [W+1];
   logic [2:0]            cneg_in  [W+1];
   logic [2:0][W-1:0]     q_ff     [W+1];
   logic [2:0][W-1:0]     q_in     [W+1];
   logic [LW-1:0]         dot_ff   [W+1];
   logic [LW-1:0]         dot_in   [W+1];
   logic [LW-1:0]         len_ff   [W+1];
   logic [LW-1:0]         len_in   [W+1];

   ctl_type               out_ctl_ff;
   logic [2:0][W-1:0]     out_n_ff, out_n_in;
   logic [2:0][W-1:0]     out_q_ff;

   logic [1:0]            region;

   // Classify the request: degenerate, before start, beyond end or interior
   always_comb begin
      if (in_len == '0) begin
         region = REGION_DEGENERATE;
      end else if (in_dot[DW-1]) begin
         region = REGION_START;
      end else if ($signed(in_dot) > $signed({2'b00, in_len})) begin
         region = REGION_END;
      end else begin
         region = REGION_INTERIOR;
      end
   end

   // Load the first stage: clear remainder and quotient, split the direction
   assign ctl_in[0].valid  = in_valid;
   assign ctl_in[0].region = region;
   assign r_in[0]          = '0;
   assign qq_in[0]         = '0;
   assign q_in[0]          = in_q;
   assign dot_in[0]        = in_dot[LW-1:0];
   assign len_in[0]        = in_len;
   for (genvar k = 0; k < 3; k++) begin : g_load
      logic [AW-1:0] neg_c;
      assign neg_c         = -in_c[k];
      assign cneg_in[0][k] = in_c[k][AW-1];
      assign cmag_in[0][k] = in_c[k][AW-1] ? neg_c[W-1:0] : in_c[k][W-1:0];
   end

   // One bit of |c| a stage: shift, add dot on a set bit, reduce modulo len
   for (genvar j = 0; j < W; j++) begin : g_step
      logic [RW-1:0] len_x, dot_x;
      assign len_x       = {1'b0, len_ff[j]};
      assign dot_x       = {1'b0, dot_ff[j]};
      assign ctl_in[j+1]  = ctl_ff[j];
      assign cmag_in[j+1] = cmag_ff[j];
      assign cneg_in[j+1] = cneg_ff[j];
      assign q_in[j+1]    = q_ff[j];
      assign dot_in[j+1]  = dot_ff[j];
      assign len_in[j+1]  = len_ff[j];
      for (genvar k = 0; k < 3; k++) begin : g_axis
         logic [RW-1:0] r2, r3, r4;
         logic          inc1, inc2;
         assign r2   = {r_ff[j][k][RW-2:0], 1'b0};
         assign inc1 = (r2 >= len_x);
         assign r3   = inc1 ? (r2 - len_x) : r2;
         assign r4   = cmag_ff[j][k][W-1-j] ? (r3 + dot_x) : r3;
         assign inc2 = (r4 >= len_x);
         assign r_in[j+1][k]  = inc2 ? (r4 - len_x) : r4;
         assign qq_in[j+1][k] = {qq_ff[j][k][W-2:0], 1'b0} + W'(inc1) + W'(inc2);
      end
   end

   // Round the offset to nearest and pick the nearest point by region
   for (genvar k = 0; k < 3; k++) begin : g_place
      logic          up;
      logic [W-1:0]  off;
      logic [AW-1:0] off_x, sum_x;
      assign up    = ({r_ff[W][k], 1'b0} >= {2'b00, len_ff[W]});
      assign off   = qq_ff[W][k] + W'(up);
      assign off_x = cneg_ff[W][k] ? -{1'b0, off} : {1'b0, off};
      assign sum_x = {seg_start[k][W-1], seg_start[k]} + off_x;
      always_comb begin
         case (ctl_ff[W].region)
            REGION_END:      out_n_in[k] = seg_end[k];
            REGION_INTERIOR: out_n_in[k] = sum_x[W-1:0];
            default:         out_n_in[k] = seg_start[k];
         endcase
      end
   end

   // Advance control
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= W; j++) begin
            ctl_ff[j] <= '0;
         end
         out_ctl_ff <= '0;
      end else if (en) begin
         ctl_ff     <= ctl_in;
         out_ctl_ff <= ctl_ff[W];
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         r_ff     <= r_in;
         qq_ff    <= qq_in;
         cmag_ff  <= cmag_in;
         cneg_ff  <= cneg_in;
         q_ff     <= q_in;
         dot_ff   <= dot_in;
         len_ff   <= len_in;
         out_n_ff <= out_n_in;
         out_q_ff <= q_ff[W];
      end
   end

   assign out_ctl = out_ctl_ff;
   assign out_q   = out_q_ff;
   assign out_n   = out_n_ff;

endmodule

FILE: rtl/psd_dist.sv
// Distance pipeline: squared differences, their sum and a rounded square root.
`timescale 1ns / 1ps

module psd_dist import psd_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  ctl_type                            in_ctl,
   input  logic [2:0][COORD_WIDTH-1:0]        in_q,
   input  logic [2:0][COORD_WIDTH-1:0]        in_n,
   output ctl_type                            out_ctl,
   output logic [2:0][COORD_WIDTH-1:0]        out_n,
   output logic [COORD_WIDTH:0]               out_distance
);

   localparam int W   = COORD_WIDTH;
   localparam int AW  = W + 1;
   localparam int PW  = 2 * AW;
   localparam int SW  = 2 * W + 2;
   localparam int N   = W + 1;
   localparam int RSW = N + 3;

   ctl_type               ctl1_ff, ctl2_ff;
   logic [2:0][W-1:0]     n1_ff, n2_ff;
   logic [2:0][AW-1:0]    d1_ff, d_in;
   logic [2:0][2*W-1:0]   sq2_ff;
   logic [2:0][PW-1:0]    sq_in;
   logic [SW-1:0]         sum_in;

   ctl_type               ctl_ff  [N+1];
   ctl_type               ctl_in  [N+1];
   logic [2:0][W-1:0]     n_ff    [N+1];
   logic [2:0][W-1:0]     n_in    [N+1];
   logic [SW-1:0]         s_ff    [N+1];
   logic [SW-1:0]         s_in    [N+1];
   logic [N-1:0]          root_ff [N+1];
   logic [N-1:0]          root_in [N+1];
   logic [RSW-1:0]        rem_ff  [N+1];
   logic [RSW-1:0]        rem_in  [N+1];

   logic                  up;

   // Query minus nearest point, then its square
   for (genvar k = 0; k < 3; k++) begin : g_diff
      assign d_in[k]  = {in_q[k][W-1], in_q[k]} - {in_n[k][W-1], in_n[k]};
      assign sq_in[k] = $signed(d1_ff[k]) * $signed(d1_ff[k]);
   end

   assign sum_in = {2'b00, sq2_ff[0]} + {2'b00, sq2_ff[1]} + {2'b00, sq2_ff[2]};

   // Load the root stage
   assign ctl_in[0]  = ctl2_ff;
   assign n_in[0]    = n2_ff;
   assign s_in[0]    = sum_in;
   assign root_in[0] = '0;
   assign rem_in[0]  = '0;

   // One root bit a stage from the next pair of radicand bits
   for (genvar i = 0; i < N; i++) begin : g_root
      localparam int P = N - 1 - i;
      logic [RSW-1:0] rs, trial;
      logic           ge;
      assign rs    = {rem_ff[i][RSW-3:0], s_ff[i][2*P+1:2*P]};
      assign trial = {1'b0, root_ff[i], 2'b01};
      assign ge    = (rs >= trial);
      assign rem_in[i+1]  = ge ? (rs - trial) : rs;
      assign root_in[i+1] = {root_ff[i][N-2:0], ge};
      assign ctl_in[i+1]  = ctl_ff[i];
      assign n_in[i+1]    = n_ff[i];
      assign s_in[i+1]    = s_ff[i];
   end

   // Round to nearest: step up when the remainder exceeds the root
   assign up           = (rem_ff[N] >= ({3'b000, root_ff[N]} + RSW'(1)));
   assign out_distance = root_ff[N] + N'(up);
   assign out_ctl      = ctl_ff[N];
   assign out_n        = n_ff[N];

   // Advance control
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         for (int i = 0; i <= N; i++) begin
            ctl_ff[i] <= '0;
         end
      end else if (en) begin
         ctl1_ff <= in_ctl;
         ctl2_ff <= ctl1_ff;
         ctl_ff  <= ctl_in;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         n1_ff <= in_n;
         d1_ff <= d_in;
         n2_ff <= n1_ff;
         for (int k = 0; k < 3; k++) begin
            sq2_ff[k] <= sq_in[k][2*W-1:0];
         end
         n_ff    <= n_in;
         s_ff    <= s_in;
         root_ff <= root_in;
         rem_ff  <= rem_in;
      end
   end

endmodule

FILE: rtl/point_segment_distance_3d.sv
// Top level of the three-dimensional point to segment distance pipeline.
`timescale 1ns / 1ps

// Usage:
//   Load the segment start and end (signed Q16.16) through the csr_ port,
//   register i at byte address 4*i (8*i above 32-bit coordinates).
//   Send query points on the req_ channel (valid/ready). Each request
//   yields one response on the rsp_ channel: rounded distance (Q17.16),
//   the nearest point on the segment and a region code.
// Stages: one divider stage per bit of the segment direction and one
//   square root stage per distance bit.
// Throughput: one request a cycle while the receiver takes responses;
//   every stage is a register stage.
// Reset clears the registers to zero and empties the pipeline.
// When the receiver stalls with a response waiting, the whole pipeline
//   holds and req_ready drops; nothing is lost or repeated, and
//   req_ready returns as soon as the response is taken.
module point_segment_distance_3d import psd_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_psel,
   input  logic                                      csr_penable,
   input  logic                                      csr_pwrite,
   input  logic [csr_addr_width(COORD_WIDTH)-1:0]    csr_paddr,
   input  logic [csr_data_width(COORD_WIDTH)-1:0]    csr_pwdata,
   output logic [csr_data_width(COORD_WIDTH)-1:0]    csr_prdata,
   output logic                                      csr_pready,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic [COORD_WIDTH-1:0]                    req_query_x,
   input  logic [COORD_WIDTH-1:0]                    req_query_y,
   input  logic [COORD_WIDTH-1:0]                    req_query_z,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic [COORD_WIDTH:0]                      rsp_distance,
   output logic [COORD_WIDTH-1:0]                    rsp_nearest_x,
   output logic [COORD_WIDTH-1:0]                    rsp_nearest_y,
   output logic [COORD_WIDTH-1:0]                    rsp_nearest_z,
   output logic [1:0]                                rsp_region
);

   localparam int W = COORD_WIDTH;

   logic [2:0][W-1:0]     seg_start, seg_end, req_q;
   logic                  en;

   logic                  fr_valid;
   logic [2:0][W-1:0]     fr_q;
   logic [2:0][W:0]       fr_c;
   logic [2*W+3:0]        fr_dot;
   logic [2*W+1:0]        fr_len;

   ctl_type               sc_ctl;
   logic [2:0][W-1:0]     sc_q, sc_n;

   ctl_type               ds_ctl;
   logic [2:0][W-1:0]     ds_n;
   logic [W:0]            ds_distance;

   logic                  rsp_valid_ff;
   logic [W:0]            rsp_distance_ff;
   logic [2:0][W-1:0]     rsp_n_ff;
   logic [1:0]            rsp_region_ff;

   // Hold every stage while a response waits on a stalled receiver
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign req_q     = {req_query_z, req_query_y, req_query_x};

   psd_csr #(.COORD_WIDTH(COORD_WIDTH)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .seg_start   (seg_start),
      .seg_end     (seg_end)
   );

   psd_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_q      (req_q),
      .seg_start (seg_start),
      .seg_end   (seg_end),
      .out_valid (fr_valid),
      .out_q     (fr_q),
      .out_c     (fr_c),
      .out_dot   (fr_dot),
      .out_len   (fr_len)
   );

   psd_scale #(.COORD_WIDTH(COORD_WIDTH)) u_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_q      (fr_q),
      .in_c      (fr_c),
      .in_dot    (fr_dot),
      .in_len    (fr_len),
      .seg_start (seg_start),
      .seg_end   (seg_end),
      .out_ctl   (sc_ctl),
      .out_q     (sc_q),
      .out_n     (sc_n)
   );

   psd_dist #(.COORD_WIDTH(COORD_WIDTH)) u_dist (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_ctl       (sc_ctl),
      .in_q         (sc_q),
      .in_n         (sc_n),
      .out_ctl      (ds_ctl),
      .out_n        (ds_n),
      .out_distance (ds_distance)
   );

   // Output register: hold the response until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ds_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_distance_ff <= ds_distance;
         rsp_n_ff        <= ds_n;
         rsp_region_ff   <= ds_ctl.region;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_distance  = rsp_distance_ff;
   assign rsp_nearest_x = rsp_n_ff[0];
   assign rsp_nearest_y = rsp_n_ff[1];
   assign rsp_nearest_z = rsp_n_ff[2];
   assign rsp_region    = rsp_region_ff;

`ifndef ASSERT_OFF
   // A degenerate segment answers with its start, and start equals end
   a_degenerate_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_region_ff == REGION_DEGENERATE)
      |-> (rsp_n_ff == seg_start && seg_start == seg_end))
      else $error("degenerate response not at segment start");

   // A request clamped before the start answers with the start
   a_clamp_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_region_ff == REGION_START) |-> (rsp_n_ff == seg_start))
      else $error("start-clamped response not at segment start");

   // A request clamped beyond the end answers with the end
   a_clamp_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_region_ff == REGION_END) |-> (rsp_n_ff == seg_end))
      else $error("end-clamped response not at segment end");
`endif

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the three-dimensional point to segment distance block.
`timescale 1ns / 1ps

module testbench;
   import psd_pkg::*;

   localparam int CW = 32;
   localparam int AW = csr_addr_width(CW);
   localparam int DW = csr_data_width(CW);
   localparam int LATENCY = 2 * CW + 10;
   localparam int CYCLE_LIMIT = 400000;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic [CW:0]   distance;
      logic [CW-1:0] nearest_x;
      logic [CW-1:0] nearest_y;
      logic [CW-1:0] nearest_z;
      logic [1:0]    region;
   } seg_result_type;

   logic            clock;
   logic            reset;
   logic            csr_psel, csr_penable, csr_pwrite;
   logic [AW-1:0]   csr_paddr;
   logic [DW-1:0]   csr_pwdata;
   logic [DW-1:0]   csr_prdata;
   logic            csr_pready;
   logic            req_valid, req_ready;
   logic [CW-1:0]   req_query_x, req_query_y, req_query_z;
   logic            rsp_valid, rsp_ready;
   logic [CW:0]     rsp_distance;
   logic [CW-1:0]   rsp_nearest_x, rsp_nearest_y, rsp_nearest_z;
   logic [1:0]      rsp_region;

   // Mirror of the segment registers
   logic [CW-1:0]   seg_regs [REG_COUNT];
   seg_result_type  pending_results [$];
   int              error_count = 0;
   int              cycle_count = 0;
   bit              no_idle;

   point_segment_distance_3d #(.COORD_WIDTH(CW)) u_top (.*);

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Rounded integer square root
   function automatic logic [CW:0] rounded_sqrt(input logic [127:0] s);
      logic [127:0] res;
      logic [127:0] bitv;
      res  = '0;
      bitv = 128'd1 << 126;
      for (int i = 0; i < 64; i++) begin
         if (s >= res + bitv) begin
            s   = s - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      if (s >= res + 1) res = res + 1;
      return res[CW:0];
   endfunction

   // Nearest point on the segment and its distance to the query
   function automatic seg_result_type nearest_on_segment(input logic [CW-1:0] qx,
                                                         input logic [CW-1:0] qy,
                                                         input logic [CW-1:0] qz);
      seg_result_type r;
      wide_type s [3], e [3], q [3], a [3], c [3], n [3];
      wide_type dot, len, dsq, cm, off, d;
      logic [127:0] num, quo, rem;
      dot = 0;
      len = 0;
      dsq = 0;
      q[0] = $signed(qx);
      q[1] = $signed(qy);
      q[2] = $signed(qz);
      for (int i = 0; i < 3; i++) begin
         s[i] = $signed(seg_regs[i]);
         e[i] = $signed(seg_regs[3 + i]);
         a[i] = q[i] - s[i];
         c[i] = e[i] - s[i];
         dot  = dot + a[i] * c[i];
         len  = len + c[i] * c[i];
      end
      if (len == 0) begin
         r.region = REGION_DEGENERATE;
         for (int i = 0; i < 3; i++) n[i] = s[i];
      end else if (dot < 0) begin
         r.region = REGION_START;
         for (int i = 0; i < 3; i++) n[i] = s[i];
      end else if (dot > len) begin
         r.region = REGION_END;
         for (int i = 0; i < 3; i++) n[i] = e[i];
      end else begin
         r.region = REGION_INTERIOR;
         for (int i = 0; i < 3; i++) begin
            cm  = (c[i] < 0) ? -c[i] : c[i];
            num = dot * cm;
            quo = num / len;
            rem = num - quo * len;
            if (2 * rem >= len) quo = quo + 1;
            off  = quo;
            n[i] = s[i] + ((c[i] < 0) ? -off : off);
         end
      end
      for (int i = 0; i < 3; i++) begin
         d   = q[i] - n[i];
         dsq = dsq + d * d;
      end
      r.distance  = rounded_sqrt(dsq);
      r.nearest_x = n[0][CW-1:0];
      r.nearest_y = n[1][CW-1:0];
      r.nearest_z = n[2][CW-1:0];
      return r;
   endfunction

   // Check each response against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            seg_result_type x;
            x = pending_results.pop_front();
            if (rsp_distance !== x.distance) begin
               $error("distance: expected %0h actual %0h", x.distance, rsp_distance);
               error_count++;
            end
            if (rsp_nearest_x !== x.nearest_x) begin
               $error("nearest_x: expected %0h actual %0h", x.nearest_x, rsp_nearest_x);
               error_count++;
            end
            if (rsp_nearest_y !== x.nearest_y) begin
               $error("nearest_y: expected %0h actual %0h", x.nearest_y, rsp_nearest_y);
               error_count++;
            end
            if (rsp_nearest_z !== x.nearest_z) begin
               $error("nearest_z: expected %0h actual %0h", x.nearest_z, rsp_nearest_z);
               error_count++;
            end
            if (rsp_region !== x.region) begin
               $error("region: expected %0h actual %0h", x.region, rsp_region);
               error_count++;
            end
         end
      end
   end

   // Receiver: stall a random number of cycles before each response
   initial begin
      int gap;
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 15);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Abort on a hung run
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   // Write one register through the APB port
   task automatic csr_write(input int idx, input logic [CW-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= AW'(4 * idx);
      csr_pwdata  <= DW'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx < REG_COUNT) seg_regs[idx] = value;
   endtask

   task automatic load_segment(input logic [CW-1:0] sx, input logic [CW-1:0] sy,
                               input logic [CW-1:0] sz, input logic [CW-1:0] ex,
                               input logic [CW-1:0] ey, input logic [CW-1:0] ez);
      csr_write(0, sx);
      csr_write(1, sy);
      csr_write(2, sz);
      csr_write(3, ex);
      csr_write(4, ey);
      csr_write(5, ez);
   endtask

   // Send one query request, predicting its response on acceptance
   task automatic send_query(input logic [CW-1:0] qx, input logic [CW-1:0] qy,
                             input logic [CW-1:0] qz);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_query_x <= qx;
      req_query_y <= qy;
      req_query_z <= qz;
      do @(posedge clock); while (!req_ready);
      pending_results.insert(pending_results.size(), nearest_on_segment(qx, qy, qz));
   endtask

   // Hold off until every response is back, then let the pipeline empty
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function automatic logic [CW-1:0] small_coord();
      return CW'($urandom_range(0, 32'h0010_0000)) - CW'(32'h0008_0000);
   endfunction

   task automatic test_degenerate();
      // Reset segment is a point at the origin
      send_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_query(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_query(32'h0, 32'h0, 32'h0);
      drain();
      load_segment(32'h1234_5678, 32'hfedc_ba98, 32'h7fff_ffff,
                   32'h1234_5678, 32'hfedc_ba98, 32'h7fff_ffff);
      send_query(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      send_query(32'h1234_5678, 32'hfedc_ba98, 32'h7fff_ffff);
      drain();
   endtask

   task automatic test_extremes();
      load_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_query(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_query(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      send_query(32'h7fff_ffff, 32'h8000_0000, 32'h0);
      send_query(32'hffff_ffff, 32'h0000_0001, 32'h0);
      drain();
      load_segment(32'h7fff_ffff, 32'h8000_0000, 32'h0,
                   32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
      send_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_query(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_query(32'h0, 32'h0, 32'h0);
      drain();
   endtask

   task automatic test_parameter_edges();
      load_segment(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0);
      // Out-of-range register addresses must leave the segment alone
      csr_write(6, 32'hdead_beef);
      csr_write(7, 32'h1234_5678);
      send_query(32'h0, 32'h0005_0000, 32'hfffb_0000);       // parameter at zero
      send_query(32'h0001_0000, 32'h0000_0007, 32'h0);       // parameter at one
      send_query(32'hffff_ffff, 32'h0, 32'h0);               // just before start
      send_query(32'h0001_0001, 32'h0, 32'h0);               // just past end
      send_query(32'h0000_8000, 32'h0003_0000, 32'h0);       // midpoint
      send_query(32'h0000_5555, 32'h0, 32'h0001_0000);
      drain();
   endtask

   task automatic test_random(input int phases, input int per_phase);
      logic [CW-1:0] v [6];
      int kind;
      for (int p = 0; p < phases; p++) begin
         kind = $urandom_range(0, 9);
         for (int i = 0; i < 6; i++)
            v[i] = (kind < 4) ? $urandom() : small_coord();
         if (kind == 9) for (int i = 0; i < 3; i++) v[3 + i] = v[i];
         load_segment(v[0], v[1], v[2], v[3], v[4], v[5]);
         no_idle = (p % 4 == 3);
         for (int k = 0; k < per_phase; k++) begin
            if (kind >= 4 && $urandom_range(0, 3) != 0)
               send_query(v[0] + small_coord(), v[1] + small_coord(), v[2] + small_coord());
            else
               send_query($urandom(), $urandom(), $urandom());
            // Pause until the pipeline has emptied once mid-phase
            if (k == per_phase / 2 && p == 1) drain();
         end
         drain();
      end
      no_idle = 1'b0;
   endtask

   // Stimulus
   initial begin
      reset       <= 1'b1;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      req_valid   <= 1'b0;
      req_query_x <= '0;
      req_query_y <= '0;
      req_query_z <= '0;
      no_idle     = 1'b0;
      for (int i = 0; i < REG_COUNT; i++) seg_regs[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_degenerate();
      test_extremes();
      test_parameter_edges();
      test_random(12, 115);

      drain();
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/psd_pkg.sv
rtl/psd_csr.sv
rtl/psd_front.sv
rtl/psd_scale.sv
rtl/psd_dist.sv
rtl/point_segment_distance_3d.sv
dv/testbench.sv
